// ===== src/scak_pkg.sv =====
// Shared types and constants for the serial command acknowledge and retry unit.
`default_nettype none

package scak_pkg;

   // Characters that mark and fill a command frame.
   localparam logic [7:0] CHAR_START = 8'h21;  // '!'
   localparam logic [7:0] CHAR_END   = 8'h23;  // '#'
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_O     = 8'h4F;
   localparam logic [7:0] CHAR_K     = 8'h4B;

   // Item kinds on the request side.
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result action codes.
   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_REPORT = 2'd1;
   localparam logic [1:0] ACT_RESEND = 2'd2;
   localparam logic [1:0] ACT_SYNTAX = 2'd3;

   // Control register indexes and reset values.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RESENDS = 1'b1;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd3000;
   localparam logic [2:0]  MAX_RESENDS_RESET = 3'd3;

   // Depth of the queues between front, back and result side.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      PARSE_HUNT,
      PARSE_BODY
   } parse_state_type;

   typedef enum logic {
      LINK_IDLE,
      LINK_WAIT
   } link_state_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_TICK,
      EV_RST,
      EV_OK,
      EV_BAD
   } event_kind_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  rx_byte;
      logic [11:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [11:0] report_value;
      logic        led_red;
      logic        awaiting_ack;
   } rsp_type;

   // Classified item handed from the parser to the link controller.
   typedef struct packed {
      event_kind_type kind;
      logic [11:0]    sample;
   } event_type;

endpackage

`default_nettype wire

// ===== src/scak_fifo.sv =====
// Small first-in first-out queue used between the parser, the link controller and the outputs.
`default_nettype none

module scak_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   // Pointer and fill count update, wrapping at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only counted slots are ever read out.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== src/scak_front.sv =====
// Frame parser that turns each received byte or tick into a classified event.
`default_nettype none

module scak_front #(
   parameter int FRAME_MAX_LEN = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire scak_pkg::req_type   req,
   output scak_pkg::event_type      ev
);

   import scak_pkg::*;

   localparam int LEN_W = $clog2(FRAME_MAX_LEN + 1);
   localparam int KEEP  = 3;

   parse_state_type parse_ff, parse_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       chars_ff [0:KEEP-1];
   logic [7:0]       chars_in [0:KEEP-1];
   logic             is_byte, is_rst, is_ok;

   assign is_byte = accept && (req.cmd == CMD_BYTE);

   // Parser next state.
   always_comb begin
      parse_in = parse_ff;
      if (is_byte) begin
         case (parse_ff)
            PARSE_HUNT: begin
               if (req.rx_byte == CHAR_START) parse_in = PARSE_BODY;
            end
            PARSE_BODY: begin
               if (req.rx_byte == CHAR_END) parse_in = PARSE_HUNT;
            end
            default: parse_in = PARSE_HUNT;
         endcase
      end
   end

   // Frame body capture. Only the first three characters can decide a
   // command, so only those are kept; the length still counts to the limit.
   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      chars_in = chars_ff;
      if (is_byte) begin
         if (parse_ff == PARSE_HUNT) begin
            if (req.rx_byte == CHAR_START) begin
               len_in = '0;
               ovf_in = 1'b0;
            end
         end else if (req.rx_byte != CHAR_END) begin
            if (len_ff < LEN_W'(FRAME_MAX_LEN)) begin
               for (int i = 0; i < KEEP; i++) begin
                  if (len_ff == LEN_W'(i)) chars_in[i] = req.rx_byte;
               end
               len_in = len_ff + LEN_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   // Command decode on the stored body.
   assign is_rst = !ovf_ff && (len_ff == LEN_W'(3)) && (chars_ff[0] == CHAR_R)
                   && (chars_ff[1] == CHAR_S) && (chars_ff[2] == CHAR_T);
   assign is_ok  = !ovf_ff && (len_ff == LEN_W'(2)) && (chars_ff[0] == CHAR_O)
                   && (chars_ff[1] == CHAR_K);

   // Event classification; the command is decided on the end mark itself.
   always_comb begin
      ev.sample = req.adc_sample;
      ev.kind   = EV_NONE;
      if (req.cmd == CMD_TICK) begin
         ev.kind = EV_TICK;
      end else if ((parse_ff == PARSE_BODY) && (req.rx_byte == CHAR_END)) begin
         if (is_rst) begin
            ev.kind = EV_RST;
         end else if (is_ok) begin
            ev.kind = EV_OK;
         end else begin
            ev.kind = EV_BAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff <= PARSE_HUNT;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         parse_ff <= parse_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   // The body length never passes the frame limit.
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(FRAME_MAX_LEN))
      else $error("frame length beyond limit");

   // Overflow is only flagged once the body is full.
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == LEN_W'(FRAME_MAX_LEN)))
      else $error("overflow flagged on a short frame");

   // A byte that opens a frame starts an empty body on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (is_byte && (parse_ff == PARSE_HUNT) && (req.rx_byte == CHAR_START))
      |=> ((parse_ff == PARSE_BODY) && (len_ff == '0) && !ovf_ff))
      else $error("frame start did not clear the body");

endmodule

`default_nettype wire

// ===== src/scak_back.sv =====
// Link controller that carries out events: reports, acknowledge timeout and resends.
`default_nettype none

module scak_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [scak_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [scak_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic                                  step,
   input  wire scak_pkg::event_type                   ev,
   output scak_pkg::rsp_type                          rsp
);

   import scak_pkg::*;

   logic [15:0]    timeout_ff;
   logic [2:0]     max_resends_ff;
   link_state_type link_ff, link_in;
   logic [15:0]    timer_ff, timer_in;
   logic [2:0]     count_ff, count_in;
   logic [11:0]    held_ff, held_in;
   logic           led_ff, led_in;
   logic           expire;
   logic [2:0]     count_next;
   logic [1:0]     action;

   assign expire     = (link_ff == LINK_WAIT) && (timer_ff <= 16'd1);
   assign count_next = count_ff + 3'd1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= ACK_TIMEOUT_RESET;
         max_resends_ff <= MAX_RESENDS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACK_TIMEOUT: timeout_ff     <= csr_wdata;
            CSR_MAX_RESENDS: max_resends_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Link next state.
   always_comb begin
      link_in = link_ff;
      if (step) begin
         case (ev.kind)
            EV_RST:  link_in = LINK_WAIT;
            EV_OK:   link_in = LINK_IDLE;
            EV_BAD:  link_in = LINK_IDLE;
            EV_TICK: begin
               if (expire && !(count_next < max_resends_ff)) link_in = LINK_IDLE;
            end
            default: link_in = link_ff;
         endcase
      end
   end

   // Timer, resend count, held sample and LED.
   always_comb begin
      timer_in = timer_ff;
      count_in = count_ff;
      held_in  = held_ff;
      led_in   = led_ff;
      if (step) begin
         case (ev.kind)
            EV_RST: begin
               led_in   = 1'b0;
               held_in  = ev.sample;
               count_in = '0;
               timer_in = timeout_ff;
            end
            EV_OK: begin
               led_in = 1'b1;
            end
            EV_TICK: begin
               if (expire) begin
                  count_in = count_next;
                  timer_in = (count_next < max_resends_ff) ? timeout_ff : '0;
               end else if (link_ff == LINK_WAIT) begin
                  timer_in = timer_ff - 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // Result for the current event.
   always_comb begin
      case (ev.kind)
         EV_RST:  action = ACT_REPORT;
         EV_BAD:  action = ACT_SYNTAX;
         EV_TICK: action = expire ? ACT_RESEND : ACT_NONE;
         default: action = ACT_NONE;
      endcase
      rsp.action       = action;
      rsp.report_value = ((action == ACT_REPORT) || (action == ACT_RESEND)) ? held_in : '0;
      rsp.led_red      = led_in;
      rsp.awaiting_ack = (link_in == LINK_WAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff  <= LINK_IDLE;
         timer_ff <= '0;
         count_ff <= '0;
         led_ff   <= 1'b0;
      end else begin
         link_ff  <= link_in;
         timer_ff <= timer_in;
         count_ff <= count_in;
         led_ff   <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // A report request arms the wait with a fresh count and the new sample.
   assert property (@(posedge clock) disable iff (reset)
      (step && (ev.kind == EV_RST))
      |=> ((link_ff == LINK_WAIT) && (count_ff == '0) && (held_ff == $past(ev.sample))))
      else $error("report did not arm the acknowledge wait");

   // A resend only comes out of the waiting state.
   assert property (@(posedge clock) disable iff (reset)
      (step && (rsp.action == ACT_RESEND)) |-> (link_ff == LINK_WAIT))
      else $error("resend while idle");

   // An acknowledge ends the wait and lights the LED.
   assert property (@(posedge clock) disable iff (reset)
      (step && (ev.kind == EV_OK)) |=> ((link_ff == LINK_IDLE) && led_ff))
      else $error("acknowledge not taken");

endmodule

`default_nettype wire

// ===== src/serial_command_ack_retry_unit.sv =====
// Top level of the serial command acknowledge and retry unit.
`default_nettype none

// Each request is one received byte or one timer tick and gives exactly one
// result. A parser classifies bytes of frames "!...#" into RST, OK or invalid
// commands as they arrive; a link controller sends a report on RST, waits
// ack_timeout_ticks ticks for OK, resends the held sample up to max_resends
// times and then gives up. One request is taken every clock cycle unless the
// event queue is full; the parser classifies it in the cycle it is accepted,
// and the link controller acts on it when the event queue pops it. Two-entry
// queues sit after the parser and before the result port, so either side may
// stall alone. The user must write control registers only while no request
// is in flight; the block itself does not enforce this.
module serial_command_ack_retry_unit #(
   parameter int FRAME_MAX_LEN = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   input  wire scak_pkg::req_type                     req_data,
   output logic                                       req_full,
   output scak_pkg::rsp_type                          rsp_data,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   input  wire logic                                  csr_we,
   input  wire logic [scak_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [scak_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import scak_pkg::*;

   event_type ev_push_data, ev_pop_data;
   rsp_type   rsp_push_data;
   logic      req_accept, ev_empty, rsp_full, step;

   assign req_accept = req_push && !req_full;
   assign step       = !ev_empty && !rsp_full;

   // Parser side.
   scak_front #(
      .FRAME_MAX_LEN (FRAME_MAX_LEN)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .ev     (ev_push_data)
   );

   // Queue of classified events.
   scak_fifo #(
      .WIDTH ($bits(event_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (ev_push_data),
      .full  (req_full),
      .pop   (step),
      .rdata (ev_pop_data),
      .empty (ev_empty)
   );

   // Link controller side.
   scak_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .ev        (ev_pop_data),
      .rsp       (rsp_push_data)
   );

   // Result queue in front of the consumer.
   scak_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (step),
      .wdata (rsp_push_data),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

`default_nettype wire
